FILE: src/dspp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dspp_pkg
// Shared types, register map and the perspective denominator generator for
// the dot strip perspective projector.
// ----------------------------------------------------------------------------
package dspp_pkg;

  localparam int unsigned COL_W    = 10;
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned SW_W     = 11;
  localparam int unsigned SH_W     = 7;
  localparam int unsigned SCROLL_W = 20;
  localparam int unsigned PHASE_W  = 10;
  localparam int unsigned SCALE_W  = 15;
  localparam int unsigned CFG_AW   = 4;

  localparam int unsigned AMP  = 110;
  localparam int unsigned WAVE = 220;
  localparam int unsigned CAM  = 360;

  typedef enum logic [1:0] {
    REG_STRIP_WIDTH  = 2'd0,
    REG_STRIP_HEIGHT = 2'd1,
    REG_SCROLL_PHASE = 2'd2,
    REG_DEPTH_PHASE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SW_W-1:0]     strip_width;
    logic [SH_W-1:0]     strip_height;
    logic [SCROLL_W-1:0] scroll_phase;
    logic [PHASE_W-1:0]  depth_phase;
  } cfg_t;

  // Q.8 perspective denominator 360 + z for table entry i of a 2**lsz entry
  // sine wave.
  function automatic longint depth_den(input int unsigned i,
                                       input int unsigned lsz);
    longint unsigned pi_q30;
    longint          x;
    longint unsigned ux;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          q;
    longint          p;
    longint          z;
    logic            neg;
    pi_q30 = 64'd3373259426;
    x      = longint'((longint'(i) * longint'(2 * pi_q30)) >> lsz);
    neg    = 1'b0;
    if (x >= longint'(pi_q30)) begin
      neg = 1'b1;
      x   = x - longint'(pi_q30);
    end
    if (x > longint'(pi_q30 / 2)) x = longint'(pi_q30) - x;
    ux   = longint'(x);
    x2   = (ux * ux) >> 30;
    term = ux;
    sum  = longint'(ux);
    for (int k = 1; k <= 5; k++) begin
      term = (term * x2) >> 30;
      unique case (k)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        default: term = term / 110;
      endcase
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    q = (sum + 16384) >>> 15;
    if (q > 32767) q = 32767;
    if (neg) q = -q;
    p = longint'(AMP) * q;
    if (p >= 0) z = (p + 64) >>> 7;
    else        z = -((-p + 64) >>> 7);
    return longint'(CAM) * 256 + z;
  endfunction

endpackage
`default_nettype wire

FILE: src/dspp_scale_rom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dspp_scale_rom
// Perspective scale table, one entry per sine phase, registered read.
// ----------------------------------------------------------------------------
module dspp_scale_rom
  import dspp_pkg::*;
#(
  parameter int unsigned SINE_TABLE_SIZE = 1024
) (
  input  wire logic                               clk,
  input  wire logic [$clog2(SINE_TABLE_SIZE)-1:0] addr,
  output logic      [SCALE_W-1:0]                 data_r
);

  localparam int unsigned LS  = $clog2(SINE_TABLE_SIZE);
  localparam longint      NUM = longint'(CAM) * 256 * 16384;

  logic [SCALE_W-1:0] rom [SINE_TABLE_SIZE];

  for (genvar g = 0; g < SINE_TABLE_SIZE; g++) begin : g_rom
    localparam longint             DEN = depth_den(g, LS);
    localparam logic [SCALE_W-1:0] SCL = SCALE_W'((2 * NUM + DEN) / (2 * DEN));
    assign rom[g] = SCL;
  end

  always_ff @(posedge clk) begin
    data_r <= rom[addr];
  end

endmodule
`default_nettype wire

FILE: src/dspp_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dspp_cfg_regs
// APB register file: strip width, strip height, scroll phase, depth phase.
// ----------------------------------------------------------------------------
module dspp_cfg_regs
  import dspp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_STRIP_WIDTH:  cfg_nxt.strip_width  = pwdata[SW_W-1:0];
        REG_STRIP_HEIGHT: cfg_nxt.strip_height = pwdata[SH_W-1:0];
        REG_SCROLL_PHASE: cfg_nxt.scroll_phase = pwdata[SCROLL_W-1:0];
        REG_DEPTH_PHASE:  cfg_nxt.depth_phase  = pwdata[PHASE_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STRIP_WIDTH:  prdata = 32'(cfg_r.strip_width);
      REG_STRIP_HEIGHT: prdata = 32'(cfg_r.strip_height);
      REG_SCROLL_PHASE: prdata = 32'(cfg_r.scroll_phase);
      REG_DEPTH_PHASE:  prdata = 32'(cfg_r.depth_phase);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strip_width  <= SW_W'(432);
      cfg_r.strip_height <= SH_W'(16);
      cfg_r.scroll_phase <= '0;
      cfg_r.depth_phase  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/dot_strip_perspective_projector_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dot_strip_perspective_projector_core
// Projects one font strip texel per clock to a screen pixel with a sine
// depth wave, perspective scale and diagonal rise.
// ----------------------------------------------------------------------------
// Takes one texel request in every clock (busy stays low) and gives exactly
// one result, marked by out_valid for one cycle, after it has passed through
// the register stages; results leave in request order and cannot be held off.
// The four register stages are: strip placement and phase reciprocal multiply,
// scale table read with cull, two perspective multipliers, rounding with screen clip.
module dot_strip_perspective_projector_core
  import dspp_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH    = 320,
  parameter int unsigned SCREEN_HEIGHT   = 240,
  parameter int unsigned SINE_TABLE_SIZE = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [COL_W-1:0]                  in_strip_column,
  input  wire logic [ROW_W-1:0]                  in_strip_row,
  input  wire logic [COLOR_W-1:0]                in_texel_color,
  output logic                                   out_valid,
  output logic                                   out_draw,
  output logic      [$clog2(SCREEN_WIDTH)-1:0]   out_pixel_x,
  output logic      [$clog2(SCREEN_HEIGHT)-1:0]  out_pixel_y,
  output logic      [COLOR_W-1:0]                out_pixel_color,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [CFG_AW-1:0]                 paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);

  localparam int unsigned PXW = $clog2(SCREEN_WIDTH);
  localparam int unsigned PYW = $clog2(SCREEN_HEIGHT);
  localparam int unsigned LS  = $clog2(SINE_TABLE_SIZE);
  localparam int unsigned NW  = COL_W + 3 + LS;
  localparam int unsigned K   = NW + 9;
  localparam longint unsigned RECIP = ((64'd1 << K) + 64'd439) / 64'd440;
  localparam int unsigned PW  = 2 * NW + 1;
  localparam int unsigned WXW = 22;
  localparam int unsigned DXW = 23;
  localparam int unsigned GYW = 20;
  localparam int unsigned YSW = 24;
  localparam int unsigned XMW = 41;
  localparam int unsigned YMW = 42;
  localparam int unsigned LAT = 4;

  localparam logic signed [WXW-1:0] CULL  = WXW'((SCREEN_WIDTH + AMP) * 256);
  localparam logic signed [DXW-1:0] XCTR  = DXW'(SCREEN_WIDTH * 128);
  localparam logic signed [XMW-1:0] XOFF  = XMW'(SCREEN_WIDTH) <<< 21;
  localparam logic signed [XMW-1:0] XHALF = XMW'(1) <<< 21;
  localparam logic signed [YMW-1:0] YOFF  = YMW'(SCREEN_HEIGHT) <<< 23;
  localparam logic signed [YMW-1:0] YHALF = YMW'(1) <<< 23;

  cfg_t cfg;

  dspp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy = 1'b0;

  // stage 1: strip placement, phase reciprocal
  logic                    v1_r;
  logic                    kill1_r;
  logic [ROW_W-1:0]        row1_r;
  logic [COLOR_W-1:0]      color1_r;
  logic signed [WXW-1:0]   wx1_r;
  logic [PW-1:0]           rprod1_r;
  logic signed [WXW-1:0]   wx_a;
  logic signed [WXW-1:0]   wx_nxt;
  logic signed [WXW-1:0]   disp;
  logic [NW-1:0]           n_val;
  logic                    kill_nxt;

  always_comb begin
    wx_a   = $signed(WXW'(20'(in_strip_column) * 20'd768))
           - $signed(WXW'(cfg.scroll_phase));
    disp   = $signed(WXW'(21'(cfg.strip_width) * 21'd768));
    wx_nxt = wx_a[WXW-1] ? wx_a + disp : wx_a;
    n_val  = ((NW'(in_strip_column) * NW'(6)) << LS) + NW'(WAVE);
    kill_nxt = (in_texel_color == '0)
             || (SW_W'(in_strip_column) >= cfg.strip_width)
             || (SH_W'(in_strip_row) >= cfg.strip_height);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    kill1_r  <= kill_nxt;
    row1_r   <= in_strip_row;
    color1_r <= in_texel_color;
    wx1_r    <= wx_nxt;
    rprod1_r <= PW'(n_val) * PW'(RECIP);
  end

  // stage 2: scale table read, cull, centered offsets
  logic [LS-1:0]           rom_addr;
  logic [PHASE_W+LS-1:0]   dp_scaled;
  logic [SCALE_W-1:0]      scale2_r;
  logic                    v2_r;
  logic                    kill2_r;
  logic [COLOR_W-1:0]      color2_r;
  logic signed [DXW-1:0]   dx2_r;
  logic signed [YSW-1:0]   ys2_r;
  logic signed [DXW-1:0]   dx_nxt;
  logic signed [8:0]       rowv;
  logic signed [GYW-1:0]   gy;

  always_comb begin
    dp_scaled = ((PHASE_W + LS)'(cfg.depth_phase) << LS) >> PHASE_W;
    rom_addr  = rprod1_r[K +: LS] + dp_scaled[LS-1:0];
    dx_nxt    = DXW'(wx1_r) - XCTR;
    rowv      = $signed({2'b0, row1_r, 1'b0}) - $signed({2'b0, cfg.strip_height})
              + 9'sd1;
    gy        = GYW'(rowv) * 20'sd1536;
  end

  dspp_scale_rom #(
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (scale2_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    kill2_r  <= kill1_r || (wx1_r > CULL);
    color2_r <= color1_r;
    dx2_r    <= dx_nxt;
    ys2_r    <= YSW'(gy) + YSW'(dx_nxt);
  end

  // stage 3: perspective multiply
  logic                    v3_r;
  logic                    kill3_r;
  logic [COLOR_W-1:0]      color3_r;
  logic signed [XMW-1:0]   xm3_r;
  logic signed [YMW-1:0]   ym3_r;
  logic signed [SCALE_W:0] scale_s;

  assign scale_s = $signed({1'b0, scale2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    kill3_r  <= kill2_r;
    color3_r <= color2_r;
    xm3_r    <= XMW'(dx2_r) * XMW'(scale_s);
    ym3_r    <= YMW'(ys2_r) * YMW'(scale_s);
  end

  // stage 4: round half away from zero, clip to screen
  logic signed [XMW-1:0]   xn;
  logic signed [YMW-1:0]   yn;
  logic signed [XMW-1:0]   xr;
  logic signed [YMW-1:0]   yr;
  logic signed [XMW-1:0]   px;
  logic signed [YMW-1:0]   py;
  logic                    draw_nxt;
  logic                    out_valid_r;
  logic                    out_draw_r;
  logic [PXW-1:0]          out_pixel_x_r;
  logic [PYW-1:0]          out_pixel_y_r;
  logic [COLOR_W-1:0]      out_pixel_color_r;

  always_comb begin
    xn = xm3_r + XOFF;
    yn = ym3_r + YOFF;
    xr = xn + XHALF - XMW'(xn[XMW-1]);
    yr = yn + YHALF - YMW'(yn[YMW-1]);
    px = xr >>> 22;
    py = yr >>> 24;
    draw_nxt = v3_r && !kill3_r
            && !px[XMW-1] && (px < XMW'(SCREEN_WIDTH))
            && !py[YMW-1] && (py < YMW'(SCREEN_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_draw_r  <= 1'b0;
    end else begin
      out_valid_r <= v3_r;
      out_draw_r  <= draw_nxt;
    end
    out_pixel_x_r     <= draw_nxt ? px[PXW-1:0] : '0;
    out_pixel_y_r     <= draw_nxt ? py[PYW-1:0] : '0;
    out_pixel_color_r <= draw_nxt ? color3_r : '0;
  end

  assign out_valid       = out_valid_r;
  assign out_draw        = out_draw_r;
  assign out_pixel_x     = out_pixel_x_r;
  assign out_pixel_y     = out_pixel_y_r;
  assign out_pixel_color = out_pixel_color_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("request did not produce a result on time");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a request");

  a_draw_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_draw |-> out_valid && out_pixel_color != '0)
    else $error("draw without valid result or with transparent color");

  a_blank: assert property (@(posedge clk) disable iff (!rst_n)
    !out_draw |-> out_pixel_x == '0 && out_pixel_y == '0 && out_pixel_color == '0)
    else $error("undrawn result carries nonzero fields");

  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_draw |-> (PXW + 1)'(out_pixel_x) < (PXW + 1)'(SCREEN_WIDTH)
              && (PYW + 1)'(out_pixel_y) < (PYW + 1)'(SCREEN_HEIGHT))
    else $error("drawn pixel off screen");

endmodule
`default_nettype wire
